// ----- src/cspt_pkg.sv -----
// shared types, constants and codes for the copy-on-write group tracker
`timescale 1ns / 1ps

package cspt_pkg;

    // table geometry
    localparam int GROUP_SLOTS     = 64;
    localparam int PAGES_PER_GROUP = 128;

    // field widths
    localparam int ADDR_W = 56;
    localparam int ID_W   = 16;
    localparam int CNT_W  = 8;
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;

    // slot index, and slot count that can hold the slot total itself
    localparam int SLOT_W  = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
    localparam int SLOT_CW = $clog2(GROUP_SLOTS + 1);

    // page index within a list, and list fill that can hold the list length
    localparam int PAGE_W  = (PAGES_PER_GROUP > 1) ? $clog2(PAGES_PER_GROUP) : 1;
    localparam int PAGE_CW = $clog2(PAGES_PER_GROUP + 1);

    // flat page store
    localparam int PAGE_DEPTH = GROUP_SLOTS * PAGES_PER_GROUP;
    localparam int PAGE_AW    = (PAGE_DEPTH > 1) ? $clog2(PAGE_DEPTH) : 1;

    // id that means no group
    localparam logic [ID_W-1:0]  NO_GROUP = {ID_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 3'd0,
        OP_ADD    = 3'd1,
        OP_QUERY  = 3'd2,
        OP_INC    = 3'd3,
        OP_DEC    = 3'd4,
        OP_READ   = 3'd5
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 2'd0,
        ST_NOGROUP  = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // one group slot: id, process count and list fill
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [CNT_W-1:0]   count;
        logic [PAGE_CW-1:0] fill;
    } t_slot;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        t_slot             data;
    } t_slot_wr;

    typedef struct packed {
        logic               en;
        logic [PAGE_AW-1:0] addr;
        logic [ADDR_W-1:0]  data;
    } t_page_wr;

    // one result item
    typedef struct packed {
        logic             is_shared;
        logic [CNT_W-1:0] proc_count;
        t_status          status;
    } t_result;

endpackage

// ----- src/cow_shared_page_tracker_top.sv -----
// top level of the copy-on-write group tracker
`timescale 1ns / 1ps

// Tracks copy-on-write groups: each slot holds a group id, a saturating
// process count and a packed list of shared page addresses. One operation
// is in flight at a time. An operation scans the slot table one entry a
// cycle from its memory until the group is found; add and query then scan
// the group's list one entry a cycle from the page memory up to the fill
// mark. Slots are handed out in order and lists are tracked by a fill
// mark, so no clearing pass runs after reset and the first operation is
// taken at once. The finished result sits in an output register, so the
// next operation is accepted while that result still waits to be taken.

module cow_shared_page_tracker_top import cspt_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [OP_W-1:0]        i_opcode,
    input  logic signed [ID_W-1:0] i_group_id,
    input  logic [ADDR_W-1:0]      i_page_addr,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_is_shared,
    output logic [CNT_W-1:0]       o_proc_count,
    output logic [ST_W-1:0]        o_status
);

    logic [SLOT_W-1:0]  slot_rd_addr;
    t_slot              slot_data;
    t_slot_wr           slot_wr;
    logic [PAGE_AW-1:0] page_rd_addr;
    logic [ADDR_W-1:0]  page_data;
    t_page_wr           page_wr;
    logic               res_valid;
    t_result            res;
    logic               res_take;

    logic               r_out_valid;
    t_result            r_out;

    cspt_slot_mem u_slot_mem (
        .i_clk     (i_clk),
        .i_rd_addr (slot_rd_addr),
        .o_rd_data (slot_data),
        .i_wr      (slot_wr)
    );

    cspt_page_mem u_page_mem (
        .i_clk     (i_clk),
        .i_rd_addr (page_rd_addr),
        .o_rd_data (page_data),
        .i_wr      (page_wr)
    );

    cspt_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_group_id     (i_group_id),
        .i_page_addr    (i_page_addr),
        .o_slot_rd_addr (slot_rd_addr),
        .i_slot_data    (slot_data),
        .o_slot_wr      (slot_wr),
        .o_page_rd_addr (page_rd_addr),
        .i_page_data    (page_data),
        .o_page_wr      (page_wr),
        .o_res_valid    (res_valid),
        .o_res          (res),
        .i_res_take     (res_take)
    );

    // output register loads when empty or when its transfer completes
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_is_shared  = r_out.is_shared;
    assign o_proc_count = r_out.proc_count;
    assign o_status     = r_out.status;

endmodule

// ----- src/cspt_slot_mem.sv -----
// group slot table: one synchronous read port, one write port
`timescale 1ns / 1ps

module cspt_slot_mem import cspt_pkg::*; (
    input  logic              i_clk,
    input  logic [SLOT_W-1:0] i_rd_addr,
    output t_slot             o_rd_data,
    input  t_slot_wr          i_wr
);

    t_slot r_mem [GROUP_SLOTS];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ----- src/cspt_page_mem.sv -----
// shared page store: every group's list laid out back to back
`timescale 1ns / 1ps

module cspt_page_mem import cspt_pkg::*; (
    input  logic               i_clk,
    input  logic [PAGE_AW-1:0] i_rd_addr,
    output logic [ADDR_W-1:0]  o_rd_data,
    input  t_page_wr           i_wr
);

    logic [ADDR_W-1:0] r_mem [PAGE_DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ----- src/cspt_seq.sv -----
// operation sequencer: slot scan, page list scan and write-back
`timescale 1ns / 1ps

module cspt_seq import cspt_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [OP_W-1:0]         i_opcode,
    input  logic signed [ID_W-1:0]  i_group_id,
    input  logic [ADDR_W-1:0]       i_page_addr,
    output logic [SLOT_W-1:0]       o_slot_rd_addr,
    input  t_slot                   i_slot_data,
    output t_slot_wr                o_slot_wr,
    output logic [PAGE_AW-1:0]      o_page_rd_addr,
    input  logic [ADDR_W-1:0]       i_page_data,
    output t_page_wr                o_page_wr,
    output logic                    o_res_valid,
    output t_result                 o_res,
    input  logic                    i_res_take
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SLOT = 4'b0010,
        S_PAGE = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [SLOT_CW-1:0] r_used, n_used;
    logic               r_pend, n_pend;
    logic [OP_W-1:0]    r_op, n_op;
    logic [ID_W-1:0]    r_id, n_id;
    logic [ADDR_W-1:0]  r_pa, n_pa;
    logic [SLOT_CW-1:0] r_sidx, n_sidx;
    logic [SLOT_W-1:0]  r_pend_sidx, n_pend_sidx;
    logic [PAGE_CW-1:0] r_pidx, n_pidx;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [PAGE_CW-1:0] r_fill, n_fill;
    t_result            r_res, n_res;

    logic               slot_issue, slot_hit, slot_done;
    logic               page_issue, page_hit, page_done;
    logic [PAGE_AW-1:0] list_base;
    logic [CNT_W-1:0]   new_count;

    // base of the current group's list in the page store
    assign list_base = PAGE_AW'(PAGE_AW'(r_slot) * PAGE_AW'(PAGES_PER_GROUP));

    // scan status
    assign slot_issue = (r_sidx < r_used);
    assign slot_hit   = r_pend && (i_slot_data.id == r_id);
    assign slot_done  = slot_hit || (!r_pend && !slot_issue);
    assign page_issue = (r_pidx < r_fill);
    assign page_hit   = r_pend && (i_page_data == r_pa);
    assign page_done  = page_hit || (!r_pend && !page_issue);

    // memory read addresses follow the scan counters
    assign o_slot_rd_addr = r_sidx[SLOT_W-1:0];
    assign o_page_rd_addr = list_base + PAGE_AW'(r_pidx[PAGE_W-1:0]);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_OUT);
    assign o_res       = r_res;

    // saturating count update
    always_comb begin
        new_count = i_slot_data.count;
        if (r_op == OP_INC && i_slot_data.count != CNT_MAX) begin
            new_count = i_slot_data.count + 1'b1;
        end else if (r_op == OP_DEC && i_slot_data.count != '0) begin
            new_count = i_slot_data.count - 1'b1;
        end
    end

    // next state and memory writes
    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_pend      = 1'b0;
        n_op        = r_op;
        n_id        = r_id;
        n_pa        = r_pa;
        n_sidx      = r_sidx;
        n_pend_sidx = r_pend_sidx;
        n_pidx      = r_pidx;
        n_slot      = r_slot;
        n_count     = r_count;
        n_fill      = r_fill;
        n_res       = r_res;
        o_slot_wr   = '{en: 1'b0, addr: r_slot,
                        data: '{id: r_id, count: r_count, fill: r_fill}};
        o_page_wr   = '{en: 1'b0, addr: list_base + PAGE_AW'(r_fill[PAGE_W-1:0]),
                        data: r_pa};

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op   = i_opcode;
                    n_id   = i_group_id;
                    n_pa   = i_page_addr;
                    n_sidx = '0;
                    n_res  = '{is_shared: 1'b0, proc_count: '0, status: ST_OK};
                    if (!(i_opcode inside {[OP_CREATE:OP_READ]})) begin
                        n_state = S_OUT;
                    end else if (i_group_id == NO_GROUP) begin
                        n_res.status = ST_NOGROUP;
                        n_state      = S_OUT;
                    end else begin
                        n_state = S_SLOT;
                    end
                end
            end

            S_SLOT: begin
                // one slot read issued per cycle, compared in the cycle after
                n_pend      = slot_issue;
                n_pend_sidx = r_sidx[SLOT_W-1:0];
                if (slot_issue) begin
                    n_sidx = r_sidx + 1'b1;
                end
                if (slot_done) begin
                    n_pend  = 1'b0;
                    n_state = S_OUT;
                    if (r_op == OP_CREATE) begin
                        // first free slot is the next unused one
                        n_res.proc_count = slot_hit ? i_slot_data.count : '0;
                        if (r_used == SLOT_CW'(GROUP_SLOTS)) begin
                            n_res.status = ST_FULL;
                        end else begin
                            o_slot_wr.en   = 1'b1;
                            o_slot_wr.addr = r_used[SLOT_W-1:0];
                            o_slot_wr.data = '{id: r_id, count: '0, fill: '0};
                            n_used         = r_used + 1'b1;
                        end
                    end else if (!slot_hit) begin
                        n_res.status = ST_NOTFOUND;
                    end else begin
                        n_slot  = r_pend_sidx;
                        n_count = i_slot_data.count;
                        n_fill  = i_slot_data.fill;
                        case (r_op)
                            OP_INC, OP_DEC: begin
                                o_slot_wr.en     = 1'b1;
                                o_slot_wr.addr   = r_pend_sidx;
                                o_slot_wr.data   = '{id: r_id, count: new_count,
                                                     fill: i_slot_data.fill};
                                n_res.proc_count = new_count;
                            end
                            OP_ADD, OP_QUERY: begin
                                n_pidx  = '0;
                                n_state = S_PAGE;
                            end
                            default: begin
                                n_res.proc_count = i_slot_data.count;
                            end
                        endcase
                    end
                end
            end

            S_PAGE: begin
                // one list entry read per cycle up to the fill mark
                n_pend = page_issue;
                if (page_issue) begin
                    n_pidx = r_pidx + 1'b1;
                end
                if (page_done) begin
                    n_pend           = 1'b0;
                    n_state          = S_OUT;
                    n_res.proc_count = r_count;
                    if (r_op == OP_QUERY) begin
                        n_res.is_shared = page_hit;
                    end else if (!page_hit) begin
                        if (r_fill == PAGE_CW'(PAGES_PER_GROUP)) begin
                            n_res.status = ST_FULL;
                        end else if (r_pa != '0) begin
                            // append and bump the fill mark
                            o_page_wr.en   = 1'b1;
                            o_slot_wr.en   = 1'b1;
                            o_slot_wr.data = '{id: r_id, count: r_count,
                                               fill: r_fill + 1'b1};
                        end
                    end
                end
            end

            S_OUT: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_used  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_pend  <= n_pend;
        end
    end

    // operation and scan registers
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_id        <= n_id;
        r_pa        <= n_pa;
        r_sidx      <= n_sidx;
        r_pend_sidx <= n_pend_sidx;
        r_pidx      <= n_pidx;
        r_slot      <= n_slot;
        r_count     <= n_count;
        r_fill      <= n_fill;
        r_res       <= n_res;
    end

endmodule
